@@ rtl/core/nctt_pkg.sv @@
// Shared types and constants for the nearest-centroid topic tracker.
// Used by the controller, the datapath and the top level; depends on nothing.
package nctt_pkg;

    localparam int NUM_CENTROIDS      = 4;
    localparam int MAX_TOPICS_DEFAULT = 4;
    localparam int TOPIC_W            = 2;
    localparam int CNT_W              = 3;
    localparam int WEIGHT_W           = 16;
    localparam int FREQ_W             = 16;
    localparam int ALPHA_W            = 16;
    localparam int WARMUP_W           = 16;
    localparam int MULT_W             = 16;
    localparam int CFG_IDX_W          = 3;
    localparam int CFG_DATA_W         = 64;

    localparam logic [FREQ_W-1:0]  FREQ_ONE    = 16'hFFFF;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd6554;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTROID_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTROID_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WARMUP     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MULT_TABLE = 3'd7;

    typedef struct packed {
        logic               load;    // capture the weight
        logic               measure; // distance compare for topic idx
        logic               mul;     // form alpha * (target - f) for topic idx
        logic               upd;     // write back frequency, running argmax
        logic               finish;  // dominant check, load result register
        logic [TOPIC_W-1:0] idx;
    } nctt_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] topic_cnt;
        logic             none_active;
    } nctt_status_t;

endpackage

@@ rtl/core/nctt_ctrl.sv @@
// Sequencer for the topic tracker: walks the topics for distance, then for
// the frequency update, then issues the finish step. Uses nctt_pkg.
module nctt_ctrl
    import nctt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  logic         out_stall,
    input  nctt_status_t status,
    output nctt_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIST,
        S_MUL,
        S_UPD,
        S_FINISH
    } state_t;

    state_t             state_reg, state_next;
    logic [TOPIC_W-1:0] idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    logic               last;
    logic               can_emit;

    assign last     = (idx_reg == TOPIC_W'(status.topic_cnt - CNT_W'(1)));
    assign can_emit = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.idx        = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    idx_next   = '0;
                    state_next = status.none_active ? S_FINISH : S_DIST;
                end
            end
            S_DIST:
            begin
                cmd.measure = 1'b1;
                if (last)
                begin
                    idx_next   = '0;
                    state_next = S_MUL;
                end
                else
                begin
                    idx_next = idx_reg + TOPIC_W'(1);
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.upd = 1'b1;
                if (last)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    idx_next   = idx_reg + TOPIC_W'(1);
                    state_next = S_MUL;
                end
            end
            S_FINISH:
            begin
                // wait here while the previous result is still held
                if (can_emit)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/core/nctt_datapath.sv @@
// Datapath of the topic tracker: configuration registers, topic frequencies,
// distance compare, EMA multiply/update and the result register. Uses nctt_pkg.
module nctt_datapath
    import nctt_pkg::*;
#(
    parameter int MAX_TOPICS = MAX_TOPICS_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic signed [WEIGHT_W-1:0]  weight,
    input  nctt_cmd_t                   cmd,
    output nctt_status_t                status,
    output logic                        no_topics,
    output logic [TOPIC_W-1:0]          nearest_topic,
    output logic                        dominant_changed,
    output logic                        had_previous,
    output logic [TOPIC_W-1:0]          previous_dominant,
    output logic [TOPIC_W-1:0]          new_dominant,
    output logic [MULT_W-1:0]           new_multiplier
);

    localparam int SLOTS = (MAX_TOPICS < NUM_CENTROIDS) ? MAX_TOPICS : NUM_CENTROIDS;
    localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DIST_W = WEIGHT_W + 1;
    localparam int PROD_W = 2 * (FREQ_W + 1);
    localparam int NF_W   = FREQ_W + 3;

    // configuration
    logic signed [WEIGHT_W-1:0] centroid_reg [NUM_CENTROIDS];
    logic [CNT_W-1:0]           active_reg;
    logic [ALPHA_W-1:0]         alpha_reg;
    logic [WARMUP_W-1:0]        warmup_reg;
    logic [CFG_DATA_W-1:0]      mult_table_reg;

    // tracking state
    logic [FREQ_W-1:0]          freq_reg [SLOTS];
    logic                       dom_valid_reg;
    logic [TOPIC_W-1:0]         dom_idx_reg;
    logic [WARMUP_W-1:0]        items_reg;

    // per-item working registers
    logic signed [WEIGHT_W-1:0] weight_reg;
    logic [DIST_W-1:0]          near_gap_reg;
    logic [TOPIC_W-1:0]         best_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [FREQ_W-1:0]          max_reg;
    logic [TOPIC_W-1:0]         top_reg;

    // result register
    logic                       no_topics_reg;
    logic [TOPIC_W-1:0]         nearest_reg;
    logic                       changed_reg;
    logic                       had_prev_reg;
    logic [TOPIC_W-1:0]         prev_dom_reg;
    logic [TOPIC_W-1:0]         new_dom_reg;
    logic [MULT_W-1:0]          new_mult_reg;

    logic [CNT_W-1:0]           topic_cnt;
    logic signed [DIST_W-1:0]   diff;
    logic [DIST_W-1:0]          abs_diff;
    logic [FREQ_W-1:0]          f_cur;
    logic signed [FREQ_W:0]     target;
    logic signed [FREQ_W:0]     ema_err;
    logic signed [PROD_W-1:0]   delta_full;
    logic signed [NF_W-1:0]     nf;
    logic [FREQ_W-1:0]          nf_clamped;
    logic [WARMUP_W-1:0]        items_next;
    logic                       tracking;
    logic                       changed;

    assign topic_cnt = (active_reg > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : active_reg;
    assign status.topic_cnt   = topic_cnt;
    assign status.none_active = (topic_cnt == '0);

    // distance to centroid idx
    assign diff     = DIST_W'(weight_reg) - DIST_W'(centroid_reg[cmd.idx]);
    assign abs_diff = diff[DIST_W-1] ? DIST_W'(-diff) : DIST_W'(diff);

    // EMA step toward 1.0 for the nearest topic, toward 0 for the rest
    assign f_cur      = freq_reg[cmd.idx[IW-1:0]];
    assign target     = (cmd.idx == best_reg) ? $signed({1'b0, FREQ_ONE}) : '0;
    assign ema_err    = target - $signed({1'b0, f_cur});
    assign delta_full = prod_reg >>> 16;
    assign nf         = $signed({3'b000, f_cur}) + NF_W'(delta_full);
    assign nf_clamped = nf[NF_W-1] ? '0 :
                        (nf > $signed({3'b000, FREQ_ONE})) ? FREQ_ONE : nf[FREQ_W-1:0];

    assign items_next = (items_reg == '1) ? items_reg : items_reg + WARMUP_W'(1);
    assign tracking   = (items_next >= warmup_reg);
    assign changed    = tracking && (!dom_valid_reg || (top_reg != dom_idx_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CENTROIDS; i++)
            begin
                centroid_reg[i] <= '0;
            end
            active_reg     <= '0;
            alpha_reg      <= ALPHA_RESET;
            warmup_reg     <= '0;
            mult_table_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                freq_reg[i] <= '0;
            end
            dom_valid_reg <= 1'b0;
            dom_idx_reg   <= '0;
            items_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ACTIVE:     active_reg     <= cfg_data[CNT_W-1:0];
                REG_ALPHA:      alpha_reg      <= cfg_data[ALPHA_W-1:0];
                REG_WARMUP:     warmup_reg     <= cfg_data[WARMUP_W-1:0];
                REG_MULT_TABLE: mult_table_reg <= cfg_data;
                default:        centroid_reg[cfg_index[TOPIC_W-1:0]] <= cfg_data[WEIGHT_W-1:0];
            endcase
            // any write restarts tracking
            for (int i = 0; i < SLOTS; i++)
            begin
                freq_reg[i] <= '0;
            end
            dom_valid_reg <= 1'b0;
            dom_idx_reg   <= '0;
            items_reg     <= '0;
        end
        else
        begin
            if (cmd.upd)
            begin
                freq_reg[cmd.idx[IW-1:0]] <= nf_clamped;
            end
            if (cmd.finish && !status.none_active)
            begin
                items_reg <= items_next;
                if (changed)
                begin
                    dom_valid_reg <= 1'b1;
                    dom_idx_reg   <= top_reg;
                end
            end
        end
    end

    // working and result registers carry no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            weight_reg <= weight;
        end
        if (cmd.measure && ((cmd.idx == '0) || (abs_diff < near_gap_reg)))
        begin
            near_gap_reg <= abs_diff;
            best_reg     <= cmd.idx;
        end
        if (cmd.mul)
        begin
            prod_reg <= $signed({1'b0, alpha_reg}) * ema_err;
        end
        if (cmd.upd && ((cmd.idx == '0) || (nf_clamped > max_reg)))
        begin
            max_reg <= nf_clamped;
            top_reg <= cmd.idx;
        end
        if (cmd.finish)
        begin
            if (status.none_active)
            begin
                no_topics_reg <= 1'b1;
                nearest_reg   <= '0;
                changed_reg   <= 1'b0;
                had_prev_reg  <= 1'b0;
                prev_dom_reg  <= '0;
                new_dom_reg   <= '0;
                new_mult_reg  <= '0;
            end
            else
            begin
                no_topics_reg <= 1'b0;
                nearest_reg   <= best_reg;
                changed_reg   <= changed;
                had_prev_reg  <= changed && dom_valid_reg;
                prev_dom_reg  <= (changed && dom_valid_reg) ? dom_idx_reg : '0;
                new_dom_reg   <= changed ? top_reg : '0;
                new_mult_reg  <= changed ? mult_table_reg[{top_reg, 4'b0000} +: MULT_W] : '0;
            end
        end
    end

    assign no_topics         = no_topics_reg;
    assign nearest_topic     = nearest_reg;
    assign dominant_changed  = changed_reg;
    assign had_previous      = had_prev_reg;
    assign previous_dominant = prev_dom_reg;
    assign new_dominant      = new_dom_reg;
    assign new_multiplier    = new_mult_reg;

endmodule

@@ rtl/core/nearest_centroid_topic_tracker_top.sv @@
// Nearest-centroid topic tracker, top level.
// Joins nctt_ctrl and nctt_datapath; uses nctt_pkg.
//
// Input channel (in_valid/in_stall, weight): one signed Q8.8 weight per item.
// Output channel (out_valid/out_stall, result fields): one result per item,
// the nearest topic plus dominant-topic change information.
// Items are handled one at a time. With topics in use an item goes from
// acceptance through a capture step, one distance compare per topic, a
// multiply and then a write-back step per topic for the EMA update, and a
// finish step. With no topics in use it goes from capture straight to the
// finish step. The single shared multiplier and distance unit set this order.
// in_stall is high while an item is being worked on. A result waits in the
// output register while out_stall is high; the next item is still accepted
// and worked on, and only its finish step waits for the register to free up.
// Reset (rst_n low, asynchronous) returns the configuration to its defaults
// and clears frequencies, dominant topic and item count. Configuration
// writes are taken at any edge with cfg_we high and also clear that state;
// they are meant for when the block is idle.
module nearest_centroid_topic_tracker_top
    import nctt_pkg::*;
#(
    parameter int MAX_TOPICS = MAX_TOPICS_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [WEIGHT_W-1:0]  weight,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        no_topics,
    output logic [TOPIC_W-1:0]          nearest_topic,
    output logic                        dominant_changed,
    output logic                        had_previous,
    output logic [TOPIC_W-1:0]          previous_dominant,
    output logic [TOPIC_W-1:0]          new_dominant,
    output logic [MULT_W-1:0]           new_multiplier
);

    nctt_cmd_t    cmd;
    nctt_status_t status;

    nctt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    nctt_datapath #(
        .MAX_TOPICS (MAX_TOPICS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .weight            (weight),
        .cmd               (cmd),
        .status            (status),
        .no_topics         (no_topics),
        .nearest_topic     (nearest_topic),
        .dominant_changed  (dominant_changed),
        .had_previous      (had_previous),
        .previous_dominant (previous_dominant),
        .new_dominant      (new_dominant),
        .new_multiplier    (new_multiplier)
    );

endmodule

@@ rtl/core/nctt_checker.sv @@
// Port-level checks for the topic tracker, bound to the top level.
// Sees only the top-level ports; uses no package.
module nctt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        no_topics,
    input logic [1:0]  nearest_topic,
    input logic        dominant_changed,
    input logic        had_previous,
    input logic [1:0]  previous_dominant,
    input logic [1:0]  new_dominant,
    input logic [15:0] new_multiplier
);

    // one item at a time: an accepted item blocks the input next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after item accepted");

    // a held result stays valid and keeps its nearest topic, change flag, new dominant and multiplier
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(nearest_topic)
            && $stable(dominant_changed) && $stable(new_dominant)
            && $stable(new_multiplier)))
        else $error("held result changed");

    // no active topics: nearest topic, change flags and multiplier are zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && no_topics) |-> (nearest_topic == 2'd0 && !dominant_changed
            && !had_previous && new_multiplier == 16'd0))
        else $error("no-topic result carries data");

    // change fields only with a change, and a real change of index
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !dominant_changed) |-> (!had_previous && previous_dominant == 2'd0
            && new_dominant == 2'd0 && new_multiplier == 16'd0))
        else $error("change fields set without a change");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && had_previous) |-> (dominant_changed
            && previous_dominant != new_dominant))
        else $error("previous dominant equals new dominant");

endmodule

bind nearest_centroid_topic_tracker_top nctt_checker u_nctt_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .no_topics         (no_topics),
    .nearest_topic     (nearest_topic),
    .dominant_changed  (dominant_changed),
    .had_previous      (had_previous),
    .previous_dominant (previous_dominant),
    .new_dominant      (new_dominant),
    .new_multiplier    (new_multiplier)
);
